>>> src/mer_pkg.sv
// ----------------------------------------------------------------------------
// mer_pkg
// Shared types, constants and the micro-op store of the ellipse rasteriser.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package mer_pkg;

  localparam int WIDE_W     = 48;
  localparam int TRIG_W     = 16;
  localparam int CFG_DATA_W = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int PC_W       = 6;

  localparam logic signed [TRIG_W-1:0] COS_RESET = 16'sd16384;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CENTER_X   = 3'd0,
    CFG_CENTER_Y   = 3'd1,
    CFG_SEMI_MAJOR = 3'd2,
    CFG_SEMI_MINOR = 3'd3,
    CFG_VERTICAL   = 3'd4,
    CFG_COS_Q      = 3'd5,
    CFG_SIN_Q      = 3'd6
  } cfg_idx_e;

  typedef enum logic [2:0] {
    OA_SMAJ = 3'd0,
    OA_SMIN = 3'd1,
    OA_AA   = 3'd2,
    OA_BB   = 3'd3,
    OA_T1   = 3'd4,
    OA_T2   = 3'd5,
    OA_U    = 3'd6,
    OA_V    = 3'd7
  } opa_e;

  typedef enum logic [2:0] {
    OB_ONE  = 3'd0,
    OB_SMAJ = 3'd1,
    OB_SMIN = 3'd2,
    OB_X    = 3'd3,
    OB_Y    = 3'd4,
    OB_BB   = 3'd5,
    OB_COS  = 3'd6,
    OB_SIN  = 3'd7
  } opb_e;

  typedef enum logic [3:0] {
    D_NONE = 4'd0,
    D_AA   = 4'd1,
    D_BB   = 4'd2,
    D_KAB  = 4'd3,
    D_T1   = 4'd4,
    D_T2   = 4'd5,
    D_DEC  = 4'd6,
    D_DIAG = 4'd7,
    D_AXIS = 4'd8,
    D_SX1  = 4'd9,
    D_SY1  = 4'd10,
    D_SX2  = 4'd11,
    D_SY2  = 4'd12
  } dest_e;

  typedef enum logic [2:0] {
    END_NONE    = 3'd0,
    END_LOAD    = 3'd1,
    END_RESTART = 3'd2,
    END_ADV     = 3'd3,
    END_INIT    = 3'd4,
    END_ROT     = 3'd5
  } seg_end_e;

  localparam logic [PC_W-1:0] LOAD_PC    = 6'd0;
  localparam logic [PC_W-1:0] RESTART_PC = 6'd4;
  localparam logic [PC_W-1:0] ADV_PC     = 6'd13;
  localparam logic [PC_W-1:0] INIT_PC    = 6'd15;
  localparam logic [PC_W-1:0] ROT_PC     = 6'd30;

  typedef struct packed {
    opa_e       a_sel;
    opb_e       b_sel;
    logic       clr;
    logic       neg;
    logic [1:0] sh;
    dest_e      dest;
    seg_end_e   fin;
  } uop_t;

  typedef struct packed {
    logic       mul_en;
    logic       acc_en;
    logic       clr;
    logic       neg;
    logic [1:0] sh;
  } mac_ctrl_t;

  function automatic uop_t mk_uop(input opa_e a, input opb_e b, input logic clr,
                                  input logic neg, input logic [1:0] sh,
                                  input dest_e dest, input seg_end_e fin);
    uop_t u;
    u.a_sel = a;
    u.b_sel = b;
    u.clr   = clr;
    u.neg   = neg;
    u.sh    = sh;
    u.dest  = dest;
    u.fin   = fin;
    return u;
  endfunction

  // acc = (clr ? 0 : acc) +/- (A * B) << sh
  function automatic uop_t mer_uop(input logic [PC_W-1:0] pc);
    uop_t u;
    unique case (pc)
      // squares and 8*(aa + bb)
      6'd0:  u = mk_uop(OA_SMAJ, OB_SMAJ, 1'b1, 1'b0, 2'd0, D_AA,   END_NONE);
      6'd1:  u = mk_uop(OA_SMIN, OB_SMIN, 1'b1, 1'b0, 2'd0, D_BB,   END_NONE);
      6'd2:  u = mk_uop(OA_BB,   OB_ONE,  1'b1, 1'b0, 2'd3, D_NONE, END_NONE);
      6'd3:  u = mk_uop(OA_AA,   OB_ONE,  1'b0, 1'b0, 2'd3, D_KAB,  END_LOAD);
      // region one start terms
      6'd4:  u = mk_uop(OA_BB,   OB_ONE,  1'b1, 1'b0, 2'd2, D_NONE, END_NONE);
      6'd5:  u = mk_uop(OA_AA,   OB_ONE,  1'b0, 1'b0, 2'd0, D_NONE, END_NONE);
      6'd6:  u = mk_uop(OA_AA,   OB_SMIN, 1'b0, 1'b1, 2'd2, D_DEC,  END_NONE);
      6'd7:  u = mk_uop(OA_AA,   OB_ONE,  1'b1, 1'b0, 2'd3, D_NONE, END_NONE);
      6'd8:  u = mk_uop(OA_BB,   OB_ONE,  1'b0, 1'b0, 2'd3, D_NONE, END_NONE);
      6'd9:  u = mk_uop(OA_BB,   OB_ONE,  1'b0, 1'b0, 2'd2, D_NONE, END_NONE);
      6'd10: u = mk_uop(OA_AA,   OB_SMIN, 1'b0, 1'b1, 2'd3, D_DIAG, END_NONE);
      6'd11: u = mk_uop(OA_BB,   OB_ONE,  1'b1, 1'b0, 2'd3, D_NONE, END_NONE);
      6'd12: u = mk_uop(OA_BB,   OB_ONE,  1'b0, 1'b0, 2'd2, D_AXIS, END_RESTART);
      // region test products
      6'd13: u = mk_uop(OA_BB,   OB_X,    1'b1, 1'b0, 2'd0, D_T1,   END_NONE);
      6'd14: u = mk_uop(OA_AA,   OB_Y,    1'b1, 1'b0, 2'd0, D_T2,   END_ADV);
      // region two start terms
      6'd15: u = mk_uop(OA_T1,   OB_X,    1'b1, 1'b0, 2'd2, D_NONE, END_NONE);
      6'd16: u = mk_uop(OA_T1,   OB_ONE,  1'b0, 1'b0, 2'd2, D_NONE, END_NONE);
      6'd17: u = mk_uop(OA_BB,   OB_ONE,  1'b0, 1'b0, 2'd0, D_NONE, END_NONE);
      6'd18: u = mk_uop(OA_T2,   OB_Y,    1'b0, 1'b0, 2'd2, D_NONE, END_NONE);
      6'd19: u = mk_uop(OA_T2,   OB_ONE,  1'b0, 1'b1, 2'd3, D_NONE, END_NONE);
      6'd20: u = mk_uop(OA_AA,   OB_ONE,  1'b0, 1'b0, 2'd2, D_NONE, END_NONE);
      6'd21: u = mk_uop(OA_AA,   OB_BB,   1'b0, 1'b1, 2'd2, D_DEC,  END_NONE);
      6'd22: u = mk_uop(OA_T1,   OB_ONE,  1'b1, 1'b0, 2'd3, D_NONE, END_NONE);
      6'd23: u = mk_uop(OA_T2,   OB_ONE,  1'b0, 1'b1, 2'd3, D_NONE, END_NONE);
      6'd24: u = mk_uop(OA_BB,   OB_ONE,  1'b0, 1'b0, 2'd3, D_NONE, END_NONE);
      6'd25: u = mk_uop(OA_AA,   OB_ONE,  1'b0, 1'b0, 2'd3, D_NONE, END_NONE);
      6'd26: u = mk_uop(OA_AA,   OB_ONE,  1'b0, 1'b0, 2'd2, D_DIAG, END_NONE);
      6'd27: u = mk_uop(OA_T2,   OB_ONE,  1'b1, 1'b1, 2'd3, D_NONE, END_NONE);
      6'd28: u = mk_uop(OA_AA,   OB_ONE,  1'b0, 1'b0, 2'd3, D_NONE, END_NONE);
      6'd29: u = mk_uop(OA_AA,   OB_ONE,  1'b0, 1'b0, 2'd2, D_AXIS, END_INIT);
      // rotation sums
      6'd30: u = mk_uop(OA_U,    OB_COS,  1'b1, 1'b0, 2'd0, D_NONE, END_NONE);
      6'd31: u = mk_uop(OA_V,    OB_SIN,  1'b0, 1'b1, 2'd0, D_SX1,  END_NONE);
      6'd32: u = mk_uop(OA_U,    OB_SIN,  1'b1, 1'b0, 2'd0, D_NONE, END_NONE);
      6'd33: u = mk_uop(OA_V,    OB_COS,  1'b0, 1'b0, 2'd0, D_SY1,  END_NONE);
      6'd34: u = mk_uop(OA_U,    OB_COS,  1'b1, 1'b1, 2'd0, D_NONE, END_NONE);
      6'd35: u = mk_uop(OA_V,    OB_SIN,  1'b0, 1'b1, 2'd0, D_SX2,  END_NONE);
      6'd36: u = mk_uop(OA_U,    OB_SIN,  1'b1, 1'b1, 2'd0, D_NONE, END_NONE);
      6'd37: u = mk_uop(OA_V,    OB_COS,  1'b0, 1'b0, 2'd0, D_SY2,  END_ROT);
      default: u = mk_uop(OA_AA, OB_ONE,  1'b0, 1'b0, 2'd0, D_NONE, END_ROT);
    endcase
    return u;
  endfunction

endpackage

`default_nettype wire

>>> src/mer_if.sv
// ----------------------------------------------------------------------------
// mer_in_if / mer_out_if
// Valid/ready channels for step requests and plotted pixels.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface mer_in_if;
  logic valid;
  logic ready;
  logic restart;

  modport source (output valid, output restart, input ready);
  modport sink   (input valid, input restart, output ready);
endinterface

interface mer_out_if #(
  parameter int PIX_W = 14
);
  logic                    valid;
  logic                    ready;
  logic signed [PIX_W-1:0] pixel_x;
  logic signed [PIX_W-1:0] pixel_y;
  logic                    last_of_step;
  logic                    outline_done;

  modport source (output valid, output pixel_x, output pixel_y, output last_of_step,
                  output outline_done, input ready);
  modport sink   (input valid, input pixel_x, input pixel_y, input last_of_step,
                  input outline_done, output ready);
endinterface

`default_nettype wire

>>> src/mer_mac.sv
// ----------------------------------------------------------------------------
// mer_mac
// Shared multiply-accumulate unit: registered signed product, then a
// shifted, optionally negated add into a 48-bit wrapping accumulator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module mer_mac #(
  parameter int A_W = 34,
  parameter int B_W = 23
) (
  input  logic                          clk_i,
  input  mer_pkg::mac_ctrl_t            ctrl_i,
  input  logic [A_W-1:0]                op_a_i,
  input  logic signed [B_W-1:0]         op_b_i,
  output logic [mer_pkg::WIDE_W-1:0]    sum_o
);
  import mer_pkg::*;

  localparam int P_W = A_W + 1 + B_W;

  logic signed [P_W-1:0] prod;
  logic [WIDE_W-1:0]     prod_q;
  logic [WIDE_W-1:0]     acc_q;
  logic [WIDE_W-1:0]     shifted;
  logic [WIDE_W-1:0]     term;
  logic [WIDE_W-1:0]     base;

  assign prod    = $signed({1'b0, op_a_i}) * op_b_i;
  assign shifted = prod_q << ctrl_i.sh;
  assign term    = ctrl_i.neg ? (~shifted + WIDE_W'(1)) : shifted;
  assign base    = ctrl_i.clr ? '0 : acc_q;
  assign sum_o   = base + term;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.mul_en) begin
      prod_q <= WIDE_W'(prod);
    end
    if (ctrl_i.acc_en) begin
      acc_q <= sum_o;
    end
  end

endmodule

`default_nettype wire

>>> src/midpoint_ellipse_rasterizer_unit.sv
// ----------------------------------------------------------------------------
// midpoint_ellipse_rasterizer_unit
// Midpoint ellipse outline stepper with fixed-point rotation; each step
// transfer that restarts or advances an outline yields four symmetric pixels.
// ----------------------------------------------------------------------------
// Every arithmetic term goes through one multiply-accumulate unit; each micro-op
// passes a multiply state, then an accumulate state. Restart: 21 micro-ops, then
// 4 pixels. Advance: 14 micro-ops plus test and step, plus the region-two start
// terms on the step that enters region two, then 4 pixels. One step request at a time.
// Reset: asynchronous, active low; no outline active, centre and axes zero,
// cosine 1.0, sine 0.
`timescale 1ns / 1ps
`default_nettype none

module midpoint_ellipse_rasterizer_unit #(
  parameter int COORD_BITS = 12,
  parameter int FRAC_BITS  = 14
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [mer_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [mer_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  mer_in_if.sink                          item_i,
  mer_out_if.source                       pixel_o
);
  import mer_pkg::*;

  localparam int AX_W  = COORD_BITS - 1;
  localparam int SQ_W  = 2 * AX_W;
  localparam int KAB_W = SQ_W + 4;
  localparam int A_W   = SQ_W + COORD_BITS;
  localparam int B_W   = ((SQ_W > TRIG_W) ? SQ_W : TRIG_W) + 1;
  localparam int SUM_W = COORD_BITS + TRIG_W + 1;
  localparam int PIX_W = COORD_BITS + 2;

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_MUL  = 6'b000010,
    S_ACC  = 6'b000100,
    S_TEST = 6'b001000,
    S_STEP = 6'b010000,
    S_EMIT = 6'b100000
  } state_e;

  // configuration
  logic [COORD_BITS-1:0]    cx_q, cy_q;
  logic [AX_W-1:0]          smaj_q, smin_q;
  logic                     vert_q;
  logic signed [TRIG_W-1:0] cos_q, sin_q;

  // control
  state_e             state_q, state_d;
  logic [PC_W-1:0]    pc_q, pc_d;
  logic               region2_q, region2_d;
  logic               active_q, active_d;
  logic [1:0]         emit_k_q, emit_k_d;
  logic               out_valid_q, out_valid_d;

  // payload
  logic                    restart_q, restart_d;
  logic [SQ_W-1:0]         aa_q, aa_d, bb_q, bb_d;
  logic [KAB_W-1:0]        kab_q, kab_d;
  logic [A_W-1:0]          t1_q, t1_d, t2_q, t2_d;
  logic [WIDE_W-1:0]       dec_q, dec_d, diag_q, diag_d, axis_q, axis_d;
  logic signed [SUM_W-1:0] sx1_q, sx1_d, sy1_q, sy1_d, sx2_q, sx2_d, sy2_q, sy2_d;
  logic [COORD_BITS-1:0]   x_q, x_d, y_q, y_d;
  logic [PIX_W-1:0]        px_q, px_d, py_q, py_d;
  logic                    last_q, last_d, done_q, done_d;

  uop_t                    cur_uop;
  mac_ctrl_t               mac_ctrl;
  logic [A_W-1:0]          op_a;
  logic signed [B_W-1:0]   op_b;
  logic [WIDE_W-1:0]       acc_sum;
  logic [COORD_BITS-1:0]   u_pt, v_pt;
  logic                    in_xfer;
  logic                    out_free;
  logic [KAB_W-1:0]        aa8, bb8;
  logic signed [SUM_W-1:0] sx_sel, sy_sel;

  function automatic logic [PIX_W-1:0] place(input logic [COORD_BITS-1:0] c,
                                             input logic signed [SUM_W-1:0] s,
                                             input logic minus);
    logic signed [SUM_W-1:0] fl;
    logic [PIX_W-1:0]        addend;
    logic                    corr;
    fl     = s >>> FRAC_BITS;
    // floor plus one for a negative sum with fraction: truncation toward zero
    corr   = s[SUM_W-1] && (s[FRAC_BITS-1:0] != '0);
    addend = minus ? ~fl[PIX_W-1:0] : fl[PIX_W-1:0];
    return PIX_W'(c) + addend + PIX_W'(minus ^ corr);
  endfunction

  assign cur_uop  = mer_uop(pc_q);
  assign u_pt     = vert_q ? y_q : x_q;
  assign v_pt     = vert_q ? x_q : y_q;
  assign in_xfer  = item_i.valid && item_i.ready;
  assign out_free = !out_valid_q || pixel_o.ready;
  assign aa8      = KAB_W'(aa_q) << 3;
  assign bb8      = KAB_W'(bb_q) << 3;
  assign sx_sel   = emit_k_q[1] ? sx2_q : sx1_q;
  assign sy_sel   = emit_k_q[1] ? sy2_q : sy1_q;

  assign item_i.ready         = (state_q == S_IDLE);
  assign pixel_o.valid        = out_valid_q;
  assign pixel_o.pixel_x      = px_q;
  assign pixel_o.pixel_y      = py_q;
  assign pixel_o.last_of_step = last_q;
  assign pixel_o.outline_done = done_q;

  always_comb begin
    unique case (cur_uop.a_sel)
      OA_SMAJ: op_a = A_W'(smaj_q);
      OA_SMIN: op_a = A_W'(smin_q);
      OA_AA:   op_a = A_W'(aa_q);
      OA_BB:   op_a = A_W'(bb_q);
      OA_T1:   op_a = t1_q;
      OA_T2:   op_a = t2_q;
      OA_U:    op_a = A_W'(u_pt);
      OA_V:    op_a = A_W'(v_pt);
      default: op_a = '0;
    endcase
    unique case (cur_uop.b_sel)
      OB_ONE:  op_b = B_W'(1);
      OB_SMAJ: op_b = B_W'(smaj_q);
      OB_SMIN: op_b = B_W'(smin_q);
      OB_X:    op_b = B_W'(x_q);
      OB_Y:    op_b = B_W'(y_q);
      OB_BB:   op_b = B_W'(bb_q);
      OB_COS:  op_b = B_W'(cos_q);
      OB_SIN:  op_b = B_W'(sin_q);
      default: op_b = '0;
    endcase
  end

  assign mac_ctrl.mul_en = (state_q == S_MUL);
  assign mac_ctrl.acc_en = (state_q == S_ACC);
  assign mac_ctrl.clr    = cur_uop.clr;
  assign mac_ctrl.neg    = cur_uop.neg;
  assign mac_ctrl.sh     = cur_uop.sh;

  mer_mac #(
    .A_W (A_W),
    .B_W (B_W)
  ) u_mac (
    .clk_i  (clk_i),
    .ctrl_i (mac_ctrl),
    .op_a_i (op_a),
    .op_b_i (op_b),
    .sum_o  (acc_sum)
  );

  always_comb begin
    state_d     = state_q;
    pc_d        = pc_q;
    region2_d   = region2_q;
    active_d    = active_q;
    emit_k_d    = emit_k_q;
    out_valid_d = out_valid_q && !pixel_o.ready;
    restart_d   = restart_q;
    aa_d        = aa_q;
    bb_d        = bb_q;
    kab_d       = kab_q;
    t1_d        = t1_q;
    t2_d        = t2_q;
    dec_d       = dec_q;
    diag_d      = diag_q;
    axis_d      = axis_q;
    sx1_d       = sx1_q;
    sy1_d       = sy1_q;
    sx2_d       = sx2_q;
    sy2_d       = sy2_q;
    x_d         = x_q;
    y_d         = y_q;
    px_d        = px_q;
    py_d        = py_q;
    last_d      = last_q;
    done_d      = done_q;

    unique case (state_q)
      S_IDLE: begin
        if (in_xfer) begin
          if (item_i.restart) begin
            active_d = 1'b0;
            if ((smaj_q != '0) || (smin_q != '0)) begin
              restart_d = 1'b1;
              pc_d      = LOAD_PC;
              state_d   = S_MUL;
            end
          end else if (active_q) begin
            restart_d = 1'b0;
            pc_d      = LOAD_PC;
            state_d   = S_MUL;
          end
        end
      end
      S_MUL: begin
        state_d = S_ACC;
      end
      S_ACC: begin
        unique case (cur_uop.dest)
          D_NONE: ;
          D_AA:   aa_d   = acc_sum[SQ_W-1:0];
          D_BB:   bb_d   = acc_sum[SQ_W-1:0];
          D_KAB:  kab_d  = acc_sum[KAB_W-1:0];
          D_T1:   t1_d   = acc_sum[A_W-1:0];
          D_T2:   t2_d   = acc_sum[A_W-1:0];
          D_DEC:  dec_d  = acc_sum;
          D_DIAG: diag_d = acc_sum;
          D_AXIS: axis_d = acc_sum;
          D_SX1:  sx1_d  = acc_sum[SUM_W-1:0];
          D_SY1:  sy1_d  = acc_sum[SUM_W-1:0];
          D_SX2:  sx2_d  = acc_sum[SUM_W-1:0];
          D_SY2:  sy2_d  = acc_sum[SUM_W-1:0];
          default: ;
        endcase
        unique case (cur_uop.fin)
          END_NONE: begin
            pc_d    = pc_q + 1'b1;
            state_d = S_MUL;
          end
          END_LOAD: begin
            pc_d    = restart_q ? RESTART_PC : ADV_PC;
            state_d = S_MUL;
          end
          END_RESTART: begin
            x_d       = '0;
            y_d       = COORD_BITS'(smin_q);
            region2_d = 1'b0;
            active_d  = 1'b1;
            pc_d      = ROT_PC;
            state_d   = S_MUL;
          end
          END_ADV: begin
            state_d = S_TEST;
          end
          END_INIT: begin
            region2_d = 1'b1;
            state_d   = S_STEP;
          end
          END_ROT: begin
            emit_k_d = '0;
            state_d  = S_EMIT;
          end
          default: state_d = S_IDLE;
        endcase
      end
      S_TEST: begin
        if (!region2_q && (t1_q > t2_q)) begin
          pc_d    = INIT_PC;
          state_d = S_MUL;
        end else begin
          state_d = S_STEP;
        end
      end
      S_STEP: begin
        if (!region2_q) begin
          x_d = x_q + 1'b1;
          if (!dec_q[WIDE_W-1]) begin
            y_d    = y_q - 1'b1;
            dec_d  = dec_q + diag_q;
            diag_d = diag_q + WIDE_W'(kab_q);
          end else begin
            dec_d  = dec_q + axis_q;
            diag_d = diag_q + WIDE_W'(bb8);
          end
          axis_d = axis_q + WIDE_W'(bb8);
        end else begin
          y_d = y_q - 1'b1;
          if (dec_q[WIDE_W-1] || (dec_q == '0)) begin
            x_d    = x_q + 1'b1;
            dec_d  = dec_q + diag_q;
            diag_d = diag_q + WIDE_W'(kab_q);
          end else begin
            dec_d  = dec_q + axis_q;
            diag_d = diag_q + WIDE_W'(aa8);
          end
          axis_d = axis_q + WIDE_W'(aa8);
        end
        pc_d    = ROT_PC;
        state_d = S_MUL;
      end
      S_EMIT: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          px_d        = place(cx_q, sx_sel, emit_k_q[0]);
          py_d        = place(cy_q, sy_sel, emit_k_q[0]);
          last_d      = (emit_k_q == 2'd3);
          done_d      = (y_q == '0);
          emit_k_d    = emit_k_q + 1'b1;
          if (emit_k_q == 2'd3) begin
            state_d = S_IDLE;
            if (y_q == '0) begin
              active_d = 1'b0;
            end
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cx_q   <= '0;
      cy_q   <= '0;
      smaj_q <= '0;
      smin_q <= '0;
      vert_q <= 1'b0;
      cos_q  <= COS_RESET;
      sin_q  <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_CENTER_X:   cx_q   <= cfg_data_i[COORD_BITS-1:0];
        CFG_CENTER_Y:   cy_q   <= cfg_data_i[COORD_BITS-1:0];
        CFG_SEMI_MAJOR: smaj_q <= cfg_data_i[AX_W-1:0];
        CFG_SEMI_MINOR: smin_q <= cfg_data_i[AX_W-1:0];
        CFG_VERTICAL:   vert_q <= cfg_data_i[0];
        CFG_COS_Q:      cos_q  <= cfg_data_i[TRIG_W-1:0];
        CFG_SIN_Q:      sin_q  <= cfg_data_i[TRIG_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      pc_q        <= '0;
      region2_q   <= 1'b0;
      active_q    <= 1'b0;
      emit_k_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      pc_q        <= pc_d;
      region2_q   <= region2_d;
      active_q    <= active_d;
      emit_k_q    <= emit_k_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    restart_q <= restart_d;
    aa_q      <= aa_d;
    bb_q      <= bb_d;
    kab_q     <= kab_d;
    t1_q      <= t1_d;
    t2_q      <= t2_d;
    dec_q     <= dec_d;
    diag_q    <= diag_d;
    axis_q    <= axis_d;
    sx1_q     <= sx1_d;
    sy1_q     <= sy1_d;
    sx2_q     <= sx2_d;
    sy2_q     <= sy2_d;
    x_q       <= x_d;
    y_q       <= y_d;
    px_q      <= px_d;
    py_q      <= py_d;
    last_q    <= last_d;
    done_q    <= done_d;
  end

  a_idle_no_pending_pixel : assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE) |-> (emit_k_q == '0)
  ) else $error("pixel counter not at zero while idle");

  a_finished_outline_inactive : assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE) |-> !(active_q && (y_q == '0))
  ) else $error("outline still active after reaching y = 0");

  a_region_cleared_on_restart : assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    $fell(region2_q) |-> $past(state_q == S_ACC && cur_uop.fin == END_RESTART)
  ) else $error("region two left without a restart");

  a_step_needs_outline : assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_STEP) |-> active_q
  ) else $error("midpoint step taken with no active outline");

endmodule

`default_nettype wire
